>>> hdl/b64d_pkg.sv
package b64d_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MAX_RES  = 3;

  localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h3D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'h2F;
  localparam logic [CHAR_W-1:0] DASH_CHAR  = 8'h2D;
  localparam logic [CHAR_W-1:0] UNDER_CHAR = 8'h5F;
  localparam logic [SEXTET_W-1:0] SEXTET_62 = 6'd62;
  localparam logic [SEXTET_W-1:0] SEXTET_63 = 6'd63;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // Results caused by one character: bytes packed in emit order
  typedef struct packed {
    logic [MAX_RES-1:0][BYTE_W-1:0] data;
    logic [1:0]                     count;
    status_t                        status;
    logic                           eom;
  } bundle_t;

  // Map one character to {valid, sextet}
  function automatic logic [SEXTET_W:0] char_to_sextet(input logic [CHAR_W-1:0] c,
                                                       input logic url_safe);
    logic [CHAR_W-1:0] t;
    logic [SEXTET_W:0] r;
    t = '0;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r = {1'b1, t[SEXTET_W-1:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      r = {1'b1, t[SEXTET_W-1:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      r = {1'b1, t[SEXTET_W-1:0]};
    end else if (c == PLUS_CHAR) begin
      r = {1'b1, SEXTET_62};
    end else if (c == SLASH_CHAR) begin
      r = {1'b1, SEXTET_63};
    end else if (c == PAD_CHAR) begin
      r = {1'b1, {SEXTET_W{1'b0}}};
    end else if (url_safe && c == DASH_CHAR) begin
      r = {1'b1, SEXTET_62};
    end else if (url_safe && c == UNDER_CHAR) begin
      r = {1'b1, SEXTET_63};
    end
    return r;
  endfunction

endpackage

>>> hdl/b64d_decode.sv
module b64d_decode
  import b64d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              end_i,
  input  logic              url_safe_i,
  output logic              has_result_o,
  output bundle_t           bundle_o
);

  logic [SEXTET_W-1:0] held_r [MAX_RES];
  logic [1:0]          pos_r, pos_nxt;
  logic                pad3_r, pad3_nxt;
  logic                disc_r, disc_nxt;

  logic [SEXTET_W:0]   map;
  logic                ok;
  logic [SEXTET_W-1:0] sx;
  logic                is_pad;
  logic                emit1, emit2;
  logic [BYTE_W-1:0]   b0, b1, b2;

  assign map    = char_to_sextet(char_i, url_safe_i);
  assign ok     = map[SEXTET_W];
  assign sx     = map[SEXTET_W-1:0];
  assign is_pad = (char_i == PAD_CHAR);

  // Byte assembly from the held sextets and the current one
  assign b0    = {held_r[0], held_r[1][5:4]};
  assign b1    = {held_r[1][3:0], held_r[2][5:2]};
  assign b2    = {held_r[2][1:0], sx};
  assign emit1 = !pad3_r;
  assign emit2 = !is_pad;

  // Next group state and result bundle
  always_comb begin
    pos_nxt      = pos_r;
    pad3_nxt     = pad3_r;
    disc_nxt     = disc_r;
    has_result_o = 1'b0;
    bundle_o     = '{data: '0, count: 2'd1, status: ST_OK, eom: 1'b0};
    if (disc_r) begin
      if (end_i) disc_nxt = 1'b0;
    end else if (!ok) begin
      has_result_o    = 1'b1;
      bundle_o.status = ST_BAD_CHAR;
      bundle_o.eom    = end_i;
      pos_nxt         = '0;
      pad3_nxt        = 1'b0;
      disc_nxt        = !end_i;
    end else if (pos_r != 2'd3) begin
      if (pos_r == 2'd2) pad3_nxt = is_pad;
      pos_nxt = pos_r + 2'd1;
      if (end_i) begin
        has_result_o    = 1'b1;
        bundle_o.status = ST_TRUNCATED;
        bundle_o.eom    = 1'b1;
        pos_nxt         = '0;
        pad3_nxt        = 1'b0;
      end
    end else begin
      has_result_o     = 1'b1;
      bundle_o.data[0] = b0;
      bundle_o.data[1] = emit1 ? b1 : b2;
      bundle_o.data[2] = b2;
      bundle_o.count   = 2'd1 + {1'b0, emit1} + {1'b0, emit2};
      bundle_o.eom     = end_i;
      pos_nxt          = '0;
      pad3_nxt         = 1'b0;
    end
  end

  // Advance group state on each consumed character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pad3_r <= 1'b0;
      disc_r <= 1'b0;
    end else if (fire_i) begin
      pos_r  <= pos_nxt;
      pad3_r <= pad3_nxt;
      disc_r <= disc_nxt;
    end
  end

  // Hold sextets of the open group
  always_ff @(posedge clk) begin
    if (fire_i && !disc_r && ok && pos_r != 2'd3) begin
      held_r[pos_r] <= sx;
    end
  end

endmodule

>>> hdl/b64d_out_buf.sv
module b64d_out_buf
  import b64d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  bundle_t           bundle_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output status_t           out_status_o,
  output logic              out_last_o,
  output logic              out_eom_o
);

  bundle_t    bnd_r;
  logic [1:0] idx_r;
  logic       vld_r;
  logic       last;

  assign last         = (idx_r == bnd_r.count - 2'd1);
  assign free_o       = !vld_r || (last && out_ready_i);
  assign out_valid_o  = vld_r;
  assign out_byte_o   = bnd_r.data[idx_r];
  assign out_status_o = bnd_r.status;
  assign out_last_o   = last;
  assign out_eom_o    = last && bnd_r.eom;

  // Load a new bundle or step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load_i) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (vld_r && out_ready_i) begin
      if (last) vld_r <= 1'b0;
      else      idx_r <= idx_r + 2'd1;
    end
  end

  // Hold bundle payload
  always_ff @(posedge clk) begin
    if (load_i) bnd_r <= bundle_i;
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> bnd_r.count != 2'd0)
    else $error("result bundle with zero count");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> idx_r < bnd_r.count)
    else $error("result index past bundle count");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> free_o)
    else $error("bundle loaded over pending results");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && bnd_r.status != ST_OK) |-> (bnd_r.count == 2'd1 && out_byte_o == '0))
    else $error("error result must be a single zero byte");

endmodule

>>> hdl/base64_stream_decoder.sv
// Channel | Dir | Handshake                | Payload
// in_     | in  | in_tvalid / in_tready    | tdata: char_code; tlast: message_end
// out_    | out | out_tvalid / out_tready  | tdata: data_byte; tuser: status,
//         |     |                          |   last_in_run; tlast: end_of_message
// cfg_    | in  | cfg_valid / cfg_ready    | cfg_data: url_safe_mode
//
// One character is accepted per cycle unless stalled. A fourth character of a group
// yields up to three bytes, drained one per cycle from the result buffer while
// out_tready is high; a later character that causes results waits until it is free.
// Reset (rst_n low, synchronous) clears group position, discard flag and the mode.
// A stall on out_ stops only characters that cause results; others keep flowing.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,    // [7:0] char_code
  input  logic              in_tlast,    // message_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,   // [7:0] data_byte
  output logic [2:0]        out_tuser,   // [1:0] status, [2] last_in_run
  output logic              out_tlast,   // end_of_message
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data     // url_safe_mode
);

  logic              in_vld_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_end_r;
  logic              url_r;
  logic              has_result;
  logic              free;
  logic              fire;
  bundle_t           bundle;
  status_t           out_status;
  logic              out_last;

  assign fire      = in_vld_r && (!has_result || free);
  assign in_tready = !in_vld_r || fire;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  // Mode register, written on a cfg transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      url_r <= cfg_data;
    end
  end

  b64d_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire_i       (fire),
    .char_i       (in_char_r),
    .end_i        (in_end_r),
    .url_safe_i   (url_r),
    .has_result_o (has_result),
    .bundle_o     (bundle)
  );

  b64d_out_buf u_out_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_i       (fire && has_result),
    .bundle_i     (bundle),
    .free_o       (free),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_byte_o   (out_tdata),
    .out_status_o (out_status),
    .out_last_o   (out_last),
    .out_eom_o    (out_tlast)
  );

  assign out_tuser = {out_last, out_status};

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import b64d_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata;    // [7:0] char_code
  logic              in_tlast;    // message_end
  logic              out_tvalid;
  logic              out_tready;
  logic [BYTE_W-1:0] out_tdata;   // [7:0] data_byte
  logic [2:0]        out_tuser;   // [1:0] status, [2] last_in_run
  logic              out_tlast;   // end_of_message
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;    // url_safe_mode

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 0;
  bit url_mode       = 0;

  typedef struct {
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic              last;
    logic              eom;
  } dec_result_t;

  // Decoder prediction and the queue of bytes still owed by the block
  class decode_scoreboard;
    dec_result_t       owed_q[$];
    logic [5:0]        held [3];
    logic [1:0]        pos;
    logic              third_pad;
    logic              discarding;
    logic              url_safe;
    int                mismatches;

    function new();
      clear_group();
      discarding = 1'b0;
      url_safe   = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_group();
      held[0]   = '0;
      held[1]   = '0;
      held[2]   = '0;
      pos       = '0;
      third_pad = 1'b0;
    endfunction

    function void set_mode(logic m);
      url_safe = m;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Return {valid, sextet} for one character under the current alphabet
    function logic [6:0] sextet_of(logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= "A" && c <= "Z") begin
        t = c - "A";
      end else if (c >= "a" && c <= "z") begin
        t = c - "a" + 8'd26;
      end else if (c >= "0" && c <= "9") begin
        t = c - "0" + 8'd52;
      end else if (c == PLUS_CHAR || (url_safe && c == DASH_CHAR)) begin
        t = 8'(SEXTET_62);
      end else if (c == SLASH_CHAR || (url_safe && c == UNDER_CHAR)) begin
        t = 8'(SEXTET_63);
      end else if (c != PAD_CHAR) begin
        return 7'h00;
      end
      return {1'b1, t[5:0]};
    endfunction

    function void add_owed(logic [7:0] d, status_t st, logic last, logic eom);
      dec_result_t r;
      r.data   = d;
      r.status = st;
      r.last   = last;
      r.eom    = eom;
      owed_q   = {owed_q, r};
    endfunction

    // Advance the decoder by one transfer; return 1 when the block drops it
    function bit note_char(logic [7:0] c, logic e);
      logic [6:0] sx;
      logic [5:0] v;
      logic [7:0] b0, b1, b2;
      bit         emit1, emit2;
      if (discarding) begin
        if (e) discarding = 1'b0;
        return 1'b1;
      end
      sx = sextet_of(c);
      if (!sx[6]) begin
        add_owed(8'h00, ST_BAD_CHAR, 1'b1, e);
        clear_group();
        discarding = !e;
        return 1'b0;
      end
      v = sx[5:0];
      // Collect the first three sextets; an end here truncates the group
      if (pos < 2'd3) begin
        held[pos] = v;
        if (pos == 2'd2) third_pad = (c == PAD_CHAR);
        pos = pos + 2'd1;
        if (e) begin
          add_owed(8'h00, ST_TRUNCATED, 1'b1, 1'b1);
          clear_group();
        end
        return 1'b0;
      end
      b0    = {held[0], held[1][5:4]};
      b1    = {held[1][3:0], held[2][5:2]};
      b2    = {held[2][1:0], v};
      emit1 = !third_pad;
      emit2 = (c != PAD_CHAR);
      add_owed(b0, ST_OK, !(emit1 || emit2), e && !(emit1 || emit2));
      if (emit1) add_owed(b1, ST_OK, !emit2, e && !emit2);
      if (emit2) add_owed(b2, ST_OK, 1'b1, e);
      clear_group();
      return 1'b0;
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(logic [7:0] d, logic [1:0] st, logic last, logic eom);
      dec_result_t x;
      if (owed_q.size() == 0) begin
        note_mismatch($sformatf("expected none, got data %02h status %0d last %b eom %b",
                                d, st, last, eom));
        return;
      end
      x = owed_q.pop_front();
      if (x.data !== d || x.status !== st || x.last !== last || x.eom !== eom) begin
        note_mismatch($sformatf({"expected data %02h status %0d last %b eom %b, ",
                                 "got data %02h status %0d last %b eom %b"},
                                x.data, x.status, x.last, x.eom, d, st, last, eom));
      end
    endfunction
  endclass

  decode_scoreboard sb = new();

  base64_stream_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #500_000;
    $display("TEST FAILED");
    $finish;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser[1:0], out_tuser[2], out_tlast);
    end
  end

  // Drive out_tready: random stalls, plus a long hold-off on request
  initial begin : receiver
    int held_off;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (held_off = 0; held_off < HOLD_CYCLES; held_off++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one character and wait for its transfer
  task automatic send_char(input logic [7:0] c, input logic e, inout int counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!sb.note_char(c, e)) counted++;
  endtask

  task automatic send_text(input string s, input logic ends);
    int tally;
    tally = 0;
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], ends && (i == s.len() - 1), tally);
    end
  endtask

  // Drop valid and wait until every owed result has arrived, then let the pipe settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
    url_mode = m;
  endtask

  // Encode one sextet, picking either alphabet for 62 and 63 in URL-safe mode
  function automatic logic [7:0] b64_char(logic [5:0] s);
    if (s < 6'd26) return "A" + 8'(s);
    if (s < 6'd52) return "a" + 8'(s - 6'd26);
    if (s < 6'd62) return "0" + 8'(s - 6'd52);
    if (s == SEXTET_62) return (url_mode && $urandom_range(1)) ? DASH_CHAR : PLUS_CHAR;
    return (url_mode && $urandom_range(1)) ? UNDER_CHAR : SLASH_CHAR;
  endfunction

  // Build one message: mostly clean encodings, some truncated, corrupt or noise
  task automatic send_random_message(inout int counted);
    logic [7:0] text[$];
    logic [7:0] b[3];
    logic [7:0] bad;
    logic [6:0] sx;
    int         n, left, kind, i, k;
    n = $urandom_range(1, 9);
    for (i = 0; i < n; i += 3) begin
      for (k = 0; k < 3; k++) b[k] = 8'($urandom_range(255));
      left = n - i;
      text = {text, b64_char(b[0][7:2])};
      text = {text, b64_char({b[0][1:0], (left > 1) ? b[1][7:4] : 4'h0})};
      text = {text, ((left > 1) ? b64_char({b[1][3:0], (left > 2) ? b[2][7:6] : 2'b00})
                                : PAD_CHAR)};
      text = {text, ((left > 2) ? b64_char(b[2][5:0]) : PAD_CHAR)};
    end
    kind = $urandom_range(99);
    if (kind < 65) begin
      // Stray pad, one time in six, anywhere in a clean message
      if ($urandom_range(5) == 0) text[$urandom_range(text.size() - 1)] = PAD_CHAR;
    end else if (kind < 77) begin
      for (k = $urandom_range(1, 3); k > 0; k--) void'(text.pop_back());
    end else if (kind < 89) begin
      if (!url_mode && $urandom_range(2) == 0) begin
        bad = $urandom_range(1) ? DASH_CHAR : UNDER_CHAR;
      end else begin
        do begin
          bad = 8'($urandom_range(255));
          sx  = sb.sextet_of(bad);
        end while (sx[6]);
      end
      text[$urandom_range(text.size() - 1)] = bad;
    end else begin
      text.delete();
      for (k = $urandom_range(1, 8); k > 0; k--) text = {text, 8'($urandom_range(255))};
    end
    for (i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1, counted);
    end
  endtask

  task automatic run_random(input int target, input bit do_hold, input bit do_pause);
    int counted;
    bit mid_done;
    counted  = 0;
    mid_done = 1'b0;
    while (counted < target) begin
      if (!mid_done && counted >= target / 2) begin
        mid_done = 1'b1;
        if (do_hold) hold_req = 1'b1;
        if (do_pause) quiesce();
      end
      send_random_message(counted);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Standard alphabet, no idling
    write_mode(1'b0);
    send_text("TWFu", 1'b1);
    send_text("TQ==", 1'b1);
    send_text("QU=B", 1'b1);
    send_text("////", 1'b1);
    send_text("-", 1'b0);
    begin : drop_after_error
      int tally;
      tally = 0;
      send_char(8'hFF, 1'b0, tally);
      send_char("A", 1'b1, tally);
      send_char(8'h00, 1'b1, tally);
    end
    send_text("Q", 1'b1);
    send_text("QQ=", 1'b1);
    run_random(55, 1'b1, 1'b0);

    // URL-safe alphabet, idle sender
    write_mode(1'b1);
    send_idle_pct = 61;
    send_text("-_+/", 1'b1);
    send_text("_-==", 1'b1);
    run_random(55, 1'b0, 1'b1);

    // Standard alphabet, stalling receiver
    write_mode(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    run_random(55, 1'b0, 1'b0);

    // URL-safe alphabet, both sides idle now and then
    write_mode(1'b1);
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    run_random(60, 1'b0, 1'b0);

    quiesce();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/b64d_pkg.sv
hdl/b64d_decode.sv
hdl/b64d_out_buf.sv
hdl/base64_stream_decoder.sv
sim/testbench.sv
